[hw/rtl/text_token_classifier_unit_defines.svh]
// Assertion helpers used by the checker file.
`ifndef TEXT_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH
`define TEXT_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define TTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text_token_classifier_unit: assertion failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define TTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text_token_classifier_unit: assertion failed");

`endif

[hw/rtl/ttc_pkg.sv]
`default_nettype none

package ttc_pkg;

    // Width of the internal saturating word counter.
    localparam int COUNT_WIDTH = 32;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    // Word lengths of the fixed patterns and the cap of the position count.
    localparam logic [3:0] LEN_PHONE  = 4'd14;
    localparam logic [3:0] LEN_COURSE = 4'd6;
    localparam logic [3:0] LEN_DATE   = 4'd10;
    localparam logic [3:0] POS_MAX    = 4'd15;

    typedef enum logic [2:0] {
        KIND_OTHER     = 3'd0,
        KIND_PHONE     = 3'd1,
        KIND_COURSE    = 3'd2,
        KIND_DATE_OK   = 3'd3,
        KIND_DATE_BAD  = 3'd4,
        KIND_NAME_PAIR = 3'd5,
        KIND_END       = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  word_kind;
        logic [31:0] words_so_far;
        logic        is_final;
    } t_out_beat;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    // Days in a month of a non-leap year; months outside 1..12 give zero.
    function automatic logic [4:0] month_days(input logic [6:0] month);
        logic [4:0] days;
        case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: days = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    days = 5'd30;
            7'd2:                                        days = 5'd28;
            default:                                     days = 5'd0;
        endcase
        return days;
    endfunction

    // Shift one decimal digit into a 7-bit accumulator, wrapping at 128.
    function automatic logic [6:0] dec_shift(input logic [6:0] acc, input logic [7:0] c);
        logic [10:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {3'b000, c - CH_ZERO};
        return sum[6:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ttc_scan.sv]
`default_nettype none

module ttc_scan (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire ttc_pkg::t_in_beat i_beat,
    output logic                   o_have,
    output ttc_pkg::t_out_beat     o_result
);
    import ttc_pkg::*;

    logic [3:0]             r_pos,    n_pos;
    logic                   r_phone,  n_phone;
    logic                   r_course, n_course;
    logic                   r_date,   n_date;
    logic                   r_name,   n_name;
    logic [6:0]             r_month,  n_month;
    logic [6:0]             r_day,    n_day;
    logic                   r_pend,   n_pend;
    logic [COUNT_WIDTH-1:0] r_count,  n_count;

    logic [7:0]             c;
    logic                   last;
    logic                   delim;
    logic                   dig;
    logic [3:0]             t_pos;
    logic                   t_phone, t_course, t_date, t_name;
    logic [6:0]             t_month, t_day;
    logic                   close;
    logic                   date_ok;
    logic                   hit_phone, hit_course, hit_date;
    t_kind                  kind;
    logic                   pend_after;
    logic [COUNT_WIDTH-1:0] count_after;

    assign c     = i_beat.text_char;
    assign last  = i_beat.end_of_text;
    assign delim = (c == CH_SPACE) || (c == CH_NEWLINE);
    assign dig   = is_digit(c);

    // Fold the byte into the open word's pattern checks.
    always_comb begin
        t_pos    = r_pos;
        t_phone  = r_phone;
        t_course = r_course;
        t_date   = r_date;
        t_name   = r_name;
        t_month  = r_month;
        t_day    = r_day;
        if (!delim) begin
            case (r_pos)
                4'd0:       t_phone = r_phone && (c == CH_LPAREN);
                4'd4:       t_phone = r_phone && (c == CH_RPAREN);
                4'd5, 4'd9: t_phone = r_phone && (c == CH_DASH);
                default:    t_phone = r_phone && dig;
            endcase
            if (r_pos < 4'd2) begin
                t_course = r_course && (is_upper(c) || is_lower(c));
            end else begin
                t_course = r_course && dig;
            end
            if ((r_pos == 4'd2) || (r_pos == 4'd5)) begin
                t_date = r_date && (c == CH_DASH);
            end else begin
                t_date = r_date && dig;
            end
            if (r_pos == 4'd0) begin
                t_name = r_name && is_upper(c);
            end else begin
                t_name = r_name && is_lower(c);
            end
            if (dig && (r_pos < 4'd2)) begin
                t_month = dec_shift(r_month, c);
            end
            if (dig && ((r_pos == 4'd3) || (r_pos == 4'd4))) begin
                t_day = dec_shift(r_day, c);
            end
            if (r_pos != POS_MAX) begin
                t_pos = r_pos + 4'd1;
            end
        end
    end

    // A delimiter closes an open word; end of text closes whatever is open.
    assign close = delim ? (r_pos != 4'd0) : last;

    assign date_ok    = (t_month >= 7'd1) && (t_month <= 7'd12) && (t_day >= 7'd1)
                        && ({2'b00, t_day[4:0]} == t_day)
                        && (t_day[4:0] <= month_days(t_month));
    assign hit_phone  = (t_pos == LEN_PHONE) && t_phone;
    assign hit_course = (t_pos == LEN_COURSE) && t_course;
    assign hit_date   = (t_pos == LEN_DATE) && t_date;

    // Classify the closing word, phone first, then course, date, name; with no word closing, the kind is end.
    always_comb begin
        kind       = KIND_OTHER;
        pend_after = r_pend;
        if (!close) begin
            kind = KIND_END;
        end else if (hit_phone) begin
            kind = KIND_PHONE;
        end else if (hit_course) begin
            kind = KIND_COURSE;
        end else if (hit_date) begin
            kind = date_ok ? KIND_DATE_OK : KIND_DATE_BAD;
        end else if (t_name) begin
            kind       = r_pend ? KIND_NAME_PAIR : KIND_OTHER;
            pend_after = !r_pend;
        end else begin
            pend_after = 1'b0;
        end
    end

    assign count_after = (close && (r_count != '1)) ? r_count + 1'b1 : r_count;

    assign o_have                = close || last;
    assign o_result.word_kind    = kind;
    assign o_result.words_so_far = 32'(count_after);
    assign o_result.is_final     = last;

    // Next state: restart after end of text, clear the word when it closes.
    always_comb begin
        n_pos    = t_pos;
        n_phone  = t_phone;
        n_course = t_course;
        n_date   = t_date;
        n_name   = t_name;
        n_month  = t_month;
        n_day    = t_day;
        n_pend   = r_pend;
        n_count  = r_count;
        if (close || last) begin
            n_pos    = 4'd0;
            n_phone  = 1'b1;
            n_course = 1'b1;
            n_date   = 1'b1;
            n_name   = 1'b1;
            n_month  = 7'd0;
            n_day    = 7'd0;
            n_pend   = last ? 1'b0 : pend_after;
            n_count  = last ? '0 : count_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 4'd0;
            r_phone  <= 1'b1;
            r_course <= 1'b1;
            r_date   <= 1'b1;
            r_name   <= 1'b1;
            r_month  <= 7'd0;
            r_day    <= 7'd0;
            r_pend   <= 1'b0;
            r_count  <= '0;
        end else if (i_advance) begin
            r_pos    <= n_pos;
            r_phone  <= n_phone;
            r_course <= n_course;
            r_date   <= n_date;
            r_name   <= n_name;
            r_month  <= n_month;
            r_day    <= n_day;
            r_pend   <= n_pend;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/text_token_classifier_unit.sv]
`default_nettype none

// Text token classifier: takes one text byte per beat and, when a word ends
// (space, newline or end of text), gives one result beat with the word's kind
// (phone, course code, valid or invalid date, second word of a name pair,
// other, or end of text without a word), the running word count and a final
// flag. Bytes that only extend a word give no result. The block accepts one
// byte every clock as long as results are taken; an accepted byte waits in
// the input register, and any result it gives is held in the output
// register. The rate is set by the per-word scanner state, which is updated
// once per byte between the input register and the result register.
module text_token_classifier_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire ttc_pkg::t_in_beat  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output ttc_pkg::t_out_beat      o_out_data,
    input  wire logic               i_out_stall
);
    import ttc_pkg::*;

    logic      r_a_valid, n_a_valid;
    t_in_beat  r_a_beat;
    logic      r_b_valid, n_b_valid;
    t_out_beat r_b_beat;

    logic      b_free;
    logic      a_adv;
    logic      in_take;
    logic      have;
    t_out_beat result;

    // Move the held byte on whenever the result register can take its result.
    assign b_free  = !r_b_valid || !i_out_stall;
    assign a_adv   = r_a_valid && b_free;
    assign in_take = i_in_valid && !o_in_stall;

    assign o_in_stall  = r_a_valid && !b_free;
    assign o_out_valid = r_b_valid;
    assign o_out_data  = r_b_beat;

    ttc_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (a_adv),
        .i_beat    (r_a_beat),
        .o_have    (have),
        .o_result  (result)
    );

    always_comb begin
        n_a_valid = r_a_valid;
        if (in_take) begin
            n_a_valid = 1'b1;
        end else if (a_adv) begin
            n_a_valid = 1'b0;
        end
    end

    always_comb begin
        n_b_valid = r_b_valid;
        if (a_adv) begin
            n_b_valid = have;
        end else if (!i_out_stall) begin
            n_b_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
    end

    // Capture the input beat and the result beat.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_beat <= i_in_data;
        end
        if (a_adv && have) begin
            r_b_beat <= result;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ttc_checker.sv]
`default_nettype none
`include "text_token_classifier_unit_defines.svh"

module ttc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire ttc_pkg::t_out_beat o_out_data,
    input wire logic               i_out_stall
);
    import ttc_pkg::*;

    // Hold a stalled result beat.
    `TTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // Never push back while the result register is empty.
    `TTC_ASSERT_NOW(a_no_idle_stall, i_clk, i_rst_n, !o_out_valid, !o_in_stall)

    // Kind code stays in its defined range.
    `TTC_ASSERT_NOW(a_kind_range, i_clk, i_rst_n, o_out_valid, o_out_data.word_kind != 3'd7)

    // An empty end of text always closes the text.
    `TTC_ASSERT_NOW(a_end_final, i_clk, i_rst_n, o_out_valid && (o_out_data.word_kind == KIND_END), o_out_data.is_final)

    // A closed word is always counted.
    `TTC_ASSERT_NOW(a_word_counted, i_clk, i_rst_n, o_out_valid && (o_out_data.word_kind != KIND_END), o_out_data.words_so_far != 32'd0)

endmodule

bind text_token_classifier_unit ttc_checker u_ttc_checker (.*);

`default_nettype wire
